FILE: hw/rtl/eatd_pkg.sv
// Shared types and constants of the exclusive-aware task dispatcher.
`default_nettype none
package eatd_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int RUN_SLOTS = 4;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
    localparam int RCW = $clog2(RUN_SLOTS + 1);

    localparam logic [1:0] CMD_ENQ = 2'd0;
    localparam logic [1:0] CMD_FIN = 2'd1;
    localparam logic [1:0] CMD_CAN = 2'd2;
    localparam logic [1:0] CMD_STOP = 2'd3;

    localparam logic [2:0] K_START = 3'd0;
    localparam logic [2:0] K_CANCELED = 3'd1;
    localparam logic [2:0] K_STOPREQ = 3'd2;
    localparam logic [2:0] K_CKPT = 3'd3;
    localparam logic [2:0] K_STATUS = 3'd4;
    localparam logic [2:0] K_REJECT = 3'd5;

    typedef struct packed {
        logic        backup;
        logic        excl;
        logic [15:0] id;
    } entry_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] id;
        logic        backup_running;
        logic [2:0]  running_count;
        logic [4:0]  queued_count;
        logic        last;
    } result_t;
endpackage
`default_nettype wire

FILE: hw/rtl/eatd_out_reg.sv
// Output register stage that holds one result transaction.
`default_nettype none
module eatd_out_reg
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire eatd_pkg::result_t din,
    output logic                   full,
    output eatd_pkg::result_t      dout,
    input  wire logic              pop
);
    logic full_reg;
    eatd_pkg::result_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (push)
            full_reg <= 1'b1;
        else if (pop)
            full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            data_reg <= din;
    end

    assign full = full_reg;
    assign dout = data_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/exclusive_aware_task_dispatcher.sv
// Top level: dispatcher sequencer with queue memory, running table and output register.
// Walks: every queue entry visited is read through the registered memory port in a read state
// and a wait state; table slots are visited one per cycle unless a full output register holds a result up.
// Throughput: one item at a time; s_tready is high only in the idle state with the output
// register empty.
// Reset: asynchronous, active low; counts and head clear, max_running becomes 4.
`default_nettype none
module exclusive_aware_task_dispatcher
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // command[1:0], task_id[17:2], exclusive[18],
                                       // is_backup[19], do_interrupt[20],
                                       // stop_running[21], clear_queued[22], zero[23]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // kind[2:0], result_task_id[18:3],
                                       // backup_running[19], running_count[22:20],
                                       // queued_count[27:23], zero[31:28]
    output logic             m_tlast
);
    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_DISP   = 12'b000000000010,
        S_DWAIT  = 12'b000000000100,
        S_STATUS = 12'b000000001000,
        S_FIN    = 12'b000000010000,
        S_CRD    = 12'b000000100000,
        S_CWAIT  = 12'b000001000000,
        S_CRUN   = 12'b000010000000,
        S_QCLR   = 12'b000100000000,
        S_QWAIT  = 12'b001000000000,
        S_CKPT   = 12'b010000000000,
        S_SRUN   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] max_reg;
    logic [eatd_pkg::QW-1:0] head_reg, head_next;
    logic [eatd_pkg::QCW-1:0] wcnt_reg, wcnt_next;
    logic [eatd_pkg::RCW-1:0] rcnt_reg, rcnt_next;
    eatd_pkg::entry_t run_reg [eatd_pkg::RUN_SLOTS];
    logic [eatd_pkg::QCW-1:0] idx_reg, idx_next;   // walk index
    logic [eatd_pkg::QCW-1:0] kept_reg, kept_next;
    logic [1:0] cmd_reg;
    logic [15:0] id_reg;
    logic intr_reg, stopr_reg, found_reg, found_next;
    logic pend_reg, pend_next;
    logic [eatd_pkg::QCW-1:0] tot_reg, tot_next;

    eatd_pkg::entry_t mem [eatd_pkg::QUEUE_DEPTH];
    eatd_pkg::entry_t rd_reg;
    logic mem_we;
    logic [eatd_pkg::QW-1:0] mem_waddr, mem_raddr;
    eatd_pkg::entry_t mem_wdata;

    logic push, full, pop, accept;
    eatd_pkg::result_t res;
    eatd_pkg::result_t dout;
    logic [eatd_pkg::RW-1:0] ridx;
    logic [eatd_pkg::RCW-1:0] limit;
    logic run_excl, run_backup;
    logic shift_en;
    logic [eatd_pkg::RCW-1:0] shift_from;
    logic app_en;
    logic cancel_more, cancel_later;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !full;
    assign pop = m_tvalid && m_tready;
    assign ridx = idx_reg[eatd_pkg::RW-1:0];

    always_comb
    begin
        run_excl = 1'b0;
        run_backup = 1'b0;
        for (int i = 0; i < eatd_pkg::RUN_SLOTS; i++)
        begin
            if (i < int'(rcnt_reg))
            begin
                run_excl = run_excl | run_reg[i].excl;
                run_backup = run_backup | run_reg[i].backup;
            end
        end
        if ({2'b00, max_reg} > 5'(eatd_pkg::RUN_SLOTS))
            limit = eatd_pkg::RCW'(eatd_pkg::RUN_SLOTS);
        else
            limit = eatd_pkg::RCW'(max_reg);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        head_next = head_reg;
        wcnt_next = wcnt_reg;
        rcnt_next = rcnt_reg;
        idx_next = idx_reg;
        kept_next = kept_reg;
        found_next = found_reg;
        pend_next = pend_reg;
        tot_next = tot_reg;
        mem_we = 1'b0;
        mem_waddr = head_reg + wcnt_reg[eatd_pkg::QW-1:0];
        mem_wdata = '{backup: s_tdata[19], excl: s_tdata[18], id: s_tdata[17:2]};
        mem_raddr = head_reg;
        push = 1'b0;
        res = '0;
        shift_en = 1'b0;
        shift_from = '0;
        app_en = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    kept_next = '0;
                    found_next = 1'b0;
                    pend_next = 1'b0;
                    case (s_tdata[1:0])
                        eatd_pkg::CMD_ENQ:
                        begin
                            if (wcnt_reg == eatd_pkg::QCW'(eatd_pkg::QUEUE_DEPTH))
                            begin
                                push = 1'b1;
                                res.kind = eatd_pkg::K_REJECT;
                                res.id = s_tdata[17:2];
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                wcnt_next = wcnt_reg + 1'b1;
                            end
                            state_next = S_DISP;
                        end
                        eatd_pkg::CMD_FIN: state_next = S_FIN;
                        eatd_pkg::CMD_CAN:
                        begin
                            tot_next = wcnt_reg;
                            state_next = S_CRD;
                        end
                        default:
                        begin
                            tot_next = wcnt_reg;
                            state_next = s_tdata[22] ? S_QCLR : S_CKPT;
                        end
                    endcase
                end
            end
            S_FIN:
            begin
                // One table slot is compared per cycle; a match closes the gap.
                if (!found_reg)
                begin
                    if (idx_reg >= eatd_pkg::QCW'(rcnt_reg))
                        state_next = S_DISP;
                    else if (run_reg[ridx].id == id_reg)
                    begin
                        found_next = 1'b1;
                        shift_en = 1'b1;
                        shift_from = eatd_pkg::RCW'(idx_reg);
                        rcnt_next = rcnt_reg - 1'b1;
                        state_next = S_DISP;
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
                else
                    state_next = S_DISP;
            end
            S_DISP:
            begin
                if (wcnt_reg != '0 && !run_excl)
                    state_next = S_DWAIT;
                else
                    state_next = S_STATUS;
            end
            S_DWAIT:
            begin
                if (!full)
                begin
                    if ((rcnt_reg != '0 && rd_reg.excl) || rcnt_reg >= limit)
                        state_next = S_STATUS;
                    else
                    begin
                        app_en = 1'b1;
                        head_next = head_reg + 1'b1;
                        wcnt_next = wcnt_reg - 1'b1;
                        rcnt_next = rcnt_reg + 1'b1;
                        push = 1'b1;
                        res.kind = eatd_pkg::K_START;
                        res.id = rd_reg.id;
                        mem_raddr = head_reg + 1'b1;
                        state_next = S_DISP;
                    end
                end
            end
            S_STATUS:
            begin
                if (!full)
                begin
                    push = 1'b1;
                    res.kind = eatd_pkg::K_STATUS;
                    res.backup_running = run_backup;
                    res.running_count = 3'(rcnt_reg);
                    res.queued_count = 5'(wcnt_reg);
                    res.last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CRD:
            begin
                // Compact the queue in place behind the head; reads stay ahead of writes.
                if (idx_reg >= tot_reg)
                begin
                    if (!pend_reg)
                    begin
                        wcnt_next = kept_reg;
                        idx_next = '0;
                        state_next = S_CRUN;
                    end
                    else if (!full)
                    begin
                        push = 1'b1;
                        res.kind = eatd_pkg::K_CANCELED;
                        res.id = id_reg;
                        res.last = !found_reg;
                        pend_next = 1'b0;
                    end
                end
                else
                begin
                    mem_raddr = head_reg + idx_reg[eatd_pkg::QW-1:0];
                    state_next = S_CWAIT;
                end
            end
            S_CWAIT:
            begin
                mem_raddr = head_reg + idx_reg[eatd_pkg::QW-1:0];
                if (rd_reg.id == id_reg)
                begin
                    // One cancelled transaction is held back so that the final one
                    // can carry tlast once the walk is over.
                    if (!pend_reg)
                    begin
                        pend_next = 1'b1;
                        idx_next = idx_reg + 1'b1;
                        state_next = S_CRD;
                    end
                    else if (!full)
                    begin
                        push = 1'b1;
                        res.kind = eatd_pkg::K_CANCELED;
                        res.id = id_reg;
                        idx_next = idx_reg + 1'b1;
                        state_next = S_CRD;
                    end
                end
                else
                begin
                    mem_we = 1'b1;
                    mem_waddr = head_reg + kept_reg[eatd_pkg::QW-1:0];
                    mem_wdata = rd_reg;
                    kept_next = kept_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                    state_next = S_CRD;
                end
            end
            S_CRUN:
            begin
                if (idx_reg >= eatd_pkg::QCW'(rcnt_reg))
                    state_next = S_IDLE;
                else if (run_reg[ridx].id != id_reg)
                    idx_next = idx_reg + 1'b1;
                else if (!full)
                begin
                    push = 1'b1;
                    res.kind = eatd_pkg::K_STOPREQ;
                    res.id = id_reg;
                    res.last = !cancel_later;
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_QCLR:
            begin
                if (idx_reg >= tot_reg)
                begin
                    head_next = '0;
                    wcnt_next = '0;
                    state_next = S_CKPT;
                end
                else
                begin
                    mem_raddr = head_reg + idx_reg[eatd_pkg::QW-1:0];
                    state_next = S_QWAIT;
                end
            end
            S_QWAIT:
            begin
                mem_raddr = head_reg + idx_reg[eatd_pkg::QW-1:0];
                if (!full)
                begin
                    push = 1'b1;
                    res.kind = eatd_pkg::K_CANCELED;
                    res.id = rd_reg.id;
                    res.last = (idx_reg + 1'b1 == tot_reg) &&
                               !(intr_reg && rcnt_reg != '0) &&
                               !(stopr_reg && rcnt_reg != '0);
                    idx_next = idx_reg + 1'b1;
                    state_next = S_QCLR;
                end
            end
            S_CKPT:
            begin
                idx_next = '0;
                if (!(intr_reg && rcnt_reg != '0))
                    state_next = stopr_reg ? S_SRUN : S_IDLE;
                else if (!full)
                begin
                    push = 1'b1;
                    res.kind = eatd_pkg::K_CKPT;
                    res.id = run_reg[0].id;
                    res.last = !(stopr_reg && rcnt_reg != '0);
                    state_next = stopr_reg ? S_SRUN : S_IDLE;
                end
            end
            S_SRUN:
            begin
                if (idx_reg >= eatd_pkg::QCW'(rcnt_reg))
                    state_next = S_IDLE;
                else if (!full)
                begin
                    push = 1'b1;
                    res.kind = eatd_pkg::K_STOPREQ;
                    res.id = run_reg[ridx].id;
                    res.last = (idx_reg + 1'b1 == eatd_pkg::QCW'(rcnt_reg));
                    idx_next = idx_reg + 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // found_reg doubles as "a stop request follows" during a cancel walk.
    always_comb
    begin
        cancel_more = 1'b0;
        cancel_later = 1'b0;
        for (int i = 0; i < eatd_pkg::RUN_SLOTS; i++)
            if (i < int'(rcnt_reg) && run_reg[i].id == id_reg)
            begin
                cancel_more = 1'b1;
                if (i > int'(idx_reg))
                    cancel_later = 1'b1;
            end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            max_reg <= 3'd4;
            head_reg <= '0;
            wcnt_reg <= '0;
            rcnt_reg <= '0;
            idx_reg <= '0;
            kept_reg <= '0;
            found_reg <= 1'b0;
            pend_reg <= 1'b0;
            tot_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                max_reg <= cfg_wdata;
            head_reg <= head_next;
            wcnt_reg <= wcnt_next;
            rcnt_reg <= rcnt_next;
            idx_reg <= idx_next;
            kept_reg <= kept_next;
            pend_reg <= pend_next;
            tot_reg <= tot_next;
            if (state_reg == S_CRD || state_reg == S_CWAIT || state_reg == S_CRUN)
                found_reg <= (state_reg == S_CRUN) ? 1'b0 : cancel_more;
            else
                found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= s_tdata[1:0];
            id_reg <= s_tdata[17:2];
            intr_reg <= s_tdata[20];
            stopr_reg <= s_tdata[21];
        end
        for (int i = 0; i < eatd_pkg::RUN_SLOTS - 1; i++)
            if (shift_en && i >= int'(shift_from))
                run_reg[i] <= run_reg[i + 1];
        if (app_en)
            run_reg[rcnt_reg[eatd_pkg::RW-1:0]] <= rd_reg;
    end

    eatd_out_reg u_out
    (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .din  (res),
        .full (full),
        .dout (dout),
        .pop  (pop)
    );

    assign m_tvalid = full;
    assign m_tlast = dout.last;
    assign m_tdata = {4'b0000, dout.queued_count, dout.running_count, dout.backup_running,
                      dout.id, dout.kind};

`ifndef NO_ASSERTIONS
    a_rcnt: assert property (@(posedge clk) disable iff (!rst_n)
        rcnt_reg <= eatd_pkg::RCW'(eatd_pkg::RUN_SLOTS))
        else $error("running table overflow");
    a_wcnt: assert property (@(posedge clk) disable iff (!rst_n)
        wcnt_reg <= eatd_pkg::QCW'(eatd_pkg::QUEUE_DEPTH))
        else $error("queue overflow");
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("result pushed into a full output register");
    a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> (cmd_reg == eatd_pkg::CMD_FIN))
        else $error("finish walk without finish command");
`endif
endmodule
`default_nettype wire
